@@ src/srr_pkg.sv @@
// Shared types and constants for the selective-repeat receiver.
package srr_pkg;

  localparam int WINDOW       = 4;
  localparam int SEQ_BITS     = 3;
  localparam int PAYLOAD_BITS = 32;
  localparam int SEQ_SPACE    = 1 << SEQ_BITS;

  // front queue
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = 1;

  // delivery counter, holds 0 .. WINDOW
  localparam int CNT_W = $clog2(WINDOW + 1);

  typedef logic [SEQ_BITS-1:0]     seq_t;
  typedef logic [PAYLOAD_BITS-1:0] pay_t;

  typedef struct packed {
    seq_t seq;
    pay_t payload;
  } srr_item_t;

  typedef enum logic {
    KIND_ACK     = 1'b0,
    KIND_DELIVER = 1'b1
  } srr_kind_e;

endpackage

@@ src/srr_front.sv @@
// Front end: takes packets, drops corrupt ones, queues good ones for the sequencer.
module srr_front import srr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  seq_t      seq_num_i,
  input  logic      checksum_ok_i,
  input  pay_t      payload_i,
  output logic      q_valid_o,
  output srr_item_t q_item_o,
  input  logic      q_pop_i
);

  srr_item_t              fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]       count_q;
  logic                   push;
  logic                   pop;

  assign in_ready_o = (count_q != (FIFO_AW+1)'(FIFO_DEPTH));
  // corrupt packets are taken and dropped here
  assign push       = in_valid_i && in_ready_o && checksum_ok_i;
  assign pop        = q_pop_i && q_valid_o;
  assign q_valid_o  = (count_q != '0);
  assign q_item_o   = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{seq: seq_num_i, payload: payload_i};
    end
  end

endmodule

@@ src/srr_back.sv @@
// Back end: window state, slot buffer and the ack/delivery sequencer.
module srr_back import srr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  srr_item_t q_item_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output logic      kind_o,
  output seq_t      ack_num_o,
  output pay_t      data_o,
  output logic      last_o
);

  typedef enum logic {
    S_IDLE,
    S_DELIV
  } state_e;

  state_e                state_q;
  seq_t                  base_q;
  logic [SEQ_SPACE-1:0]  held_q;
  logic [CNT_W-1:0]      cnt_q;
  pay_t                  slot_q [SEQ_SPACE];

  logic                  out_valid_q;
  logic                  kind_q;
  seq_t                  ack_q;
  pay_t                  data_q;
  logic                  last_q;

  logic                  out_free;
  seq_t                  seq_off;
  seq_t                  base_inc;
  logic                  in_win;
  logic                  is_new;
  logic                  go_deliv;
  logic                  deliv_last;

  assign out_free   = !out_valid_q || out_ready_i;
  assign q_pop_o    = (state_q == S_IDLE) && q_valid_i && out_free;

  assign seq_off    = q_item_i.seq - base_q;
  assign base_inc   = base_q + 1'b1;
  assign in_win     = (32'(seq_off) < 32'(WINDOW));
  assign is_new     = in_win && !held_q[q_item_i.seq];
  // base slot is held after this packet is stored
  assign go_deliv   = in_win && (held_q[base_q] || (q_item_i.seq == base_q));
  assign deliv_last = (32'(cnt_q) + 32'd1 >= 32'(WINDOW)) || !held_q[base_inc];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= '0;
      held_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= KIND_ACK;
      ack_q       <= '0;
      data_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (q_pop_o) begin
            out_valid_q <= 1'b1;
            kind_q      <= KIND_ACK;
            ack_q       <= q_item_i.seq;
            data_q      <= '0;
            last_q      <= !go_deliv;
            if (is_new) begin
              held_q[q_item_i.seq] <= 1'b1;
            end
            if (go_deliv) begin
              state_q <= S_DELIV;
              cnt_q   <= '0;
            end
          end else if (out_ready_i) begin
            out_valid_q <= 1'b0;
          end
        end
        S_DELIV: begin
          if (out_free) begin
            out_valid_q    <= 1'b1;
            kind_q         <= KIND_DELIVER;
            ack_q          <= '0;
            data_q         <= slot_q[base_q];
            last_q         <= deliv_last;
            held_q[base_q] <= 1'b0;
            base_q         <= base_inc;
            cnt_q          <= cnt_q + 1'b1;
            if (deliv_last) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && is_new) begin
      slot_q[q_item_i.seq] <= q_item_i.payload;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign ack_num_o   = ack_q;
  assign data_o      = data_q;
  assign last_o      = last_q;

endmodule

@@ src/selective_repeat_receiver.sv @@
// Selective-repeat ARQ receiver: takes packets, sends one acknowledgement per good packet,
// buffers in-window packets and delivers them in order. Corrupt packets are taken and
// dropped in the front end at one per cycle while the queue has room. Good packets wait
// in a two-entry queue for the sequencer, which sends the acknowledgement and then the
// in-order deliveries, from 0 to WINDOW (4) of them, and takes no new packet until the
// last one is issued; each result goes out through an output register. last marks the
// final result of each packet. No clearing pass is needed after reset.
module selective_repeat_receiver import srr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  seq_t seq_num_i,
  input  logic checksum_ok_i,
  input  pay_t payload_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic kind_o,
  output seq_t ack_num_o,
  output pay_t data_o,
  output logic last_o
);

  logic      q_valid;
  logic      q_pop;
  srr_item_t q_item;

  srr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .seq_num_i     (seq_num_i),
    .checksum_ok_i (checksum_ok_i),
    .payload_i     (payload_i),
    .q_valid_o     (q_valid),
    .q_item_o      (q_item),
    .q_pop_i       (q_pop)
  );

  srr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .ack_num_o   (ack_num_o),
    .data_o      (data_o),
    .last_o      (last_o)
  );

endmodule

@@ src/srr_checker.sv @@
// Port-level checks for the selective-repeat receiver, bound to the top level.
module srr_checker import srr_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input seq_t seq_num_i,
  input logic checksum_ok_i,
  input pay_t payload_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic kind_o,
  input seq_t ack_num_o,
  input pay_t data_o,
  input logic last_o
);

  // next result begins a new packet's group
  logic expect_ack_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_ack_q <= 1'b1;
    end else if (out_valid_o && out_ready_i) begin
      expect_ack_q <= last_o;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) && $stable(ack_num_o)
      && $stable(data_o) && $stable(last_o))
    else $error("result changed while stalled");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(seq_num_i)
      && $stable(checksum_ok_i) && $stable(payload_i))
    else $error("input changed while stalled");

  a_group_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((kind_o == KIND_ACK) == expect_ack_q))
    else $error("ack/delivery order broken");

  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((kind_o == KIND_ACK) ? (data_o == '0) : (ack_num_o == '0)))
    else $error("unused result field not zero");

endmodule

bind selective_repeat_receiver srr_checker u_srr_checker (.*);
